// ===== design/http_chunked_body_decoder_unit_assert.svh =====
// Assertion macros shared by the chunked body decoder modules.
`ifndef HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, checked outside reset.
`define HCBD_ASSERT_NOW(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
    else $error("hcbd assertion failed");
// Next-cycle implication, checked outside reset.
`define HCBD_ASSERT_NEXT(lbl, ant, con) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
    else $error("hcbd assertion failed");
`else
`define HCBD_ASSERT_NOW(lbl, ant, con)
`define HCBD_ASSERT_NEXT(lbl, ant, con)
`endif
`endif

// ===== design/hcbd_pkg.sv =====
// Shared types and constants of the chunked body decoder.
package hcbd_pkg;

  // Result kinds
  localparam logic [2:0] KIND_DATA       = 3'd0;
  localparam logic [2:0] KIND_COMPLETE   = 3'd1;
  localparam logic [2:0] KIND_INCOMPLETE = 3'd2;
  localparam logic [2:0] KIND_BADSIZE    = 3'd3;
  localparam logic [2:0] KIND_OVERFLOW   = 3'd4;
  localparam logic [2:0] KIND_NOCRLF     = 3'd5;

  // Characters of the framing
  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_SEMI = 8'h3B;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;

  // Everything one body byte produces: an optional data byte, then an optional status
  typedef struct packed {
    logic        has_data;
    logic [7:0]  data;
    logic        has_status;
    logic [2:0]  status_kind;
    logic [31:0] consumed;
  } rec_t;

endpackage

// ===== design/hcbd_if.sv =====
// Valid/ready channel interfaces for body bytes and decoder results.
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       end_of_buffer;
  modport source (output valid, input ready, output data_byte, output end_of_buffer);
  modport sink (input valid, output ready, input data_byte, input end_of_buffer);
endinterface

interface hcbd_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  data_out;
  logic [31:0] consumed;
  logic        last;
  modport source (output valid, input ready, output kind, output data_out,
                  output consumed, output last);
  modport sink (input valid, output ready, input kind, input data_out,
                input consumed, input last);
endinterface

// ===== design/http_chunked_body_decoder_unit.sv =====
// Top level of the HTTP/1.1 chunked body decoder.
// Usage:
//   body   : one raw body byte per beat, end_of_buffer marks the last byte of a buffer.
//   result : one result per beat; kind 0 carries a decoded byte in data_out, kinds 1..5
//            report complete (with consumed), incomplete, bad size, overflow, missing CRLF.
//            last is set on the final result that a body byte causes.
//   cfg_wr_en / cfg_wr_data write emit_data; write only while the decoder is idle.
// Timing: a byte is parsed in the cycle it is accepted; its record is written into the
//   record queue and from there loaded into the output register, where it can be taken.
//   One byte per cycle is taken while the queue has room; a byte that gives both a data
//   byte and a status needs two output beats, which the four-entry record queue absorbs.
//   The parser's state update sets the rate.
// Reset: parser re-armed at a size line start, queue empty, emit_data set.
// Stall: when result is not taken the queue fills and body.ready drops once it holds
//   four records; no result is dropped or repeated.
module http_chunked_body_decoder_unit #(
  parameter int CHUNK_SIZE_BITS = 32,
  parameter int COUNT_BITS      = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  hcbd_in_if.sink     body,
  hcbd_out_if.source  result
);

  logic           emit_data;
  logic           push, pop, full, head_valid;
  hcbd_pkg::rec_t push_rec, head_rec;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_data <= 1'b1;
    end else if (cfg_wr_en) begin
      emit_data <= cfg_wr_data;
    end
  end

  hcbd_front #(
    .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS),
    .COUNT_BITS      (COUNT_BITS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .emit_data (emit_data),
    .body      (body),
    .q_full    (full),
    .push      (push),
    .push_rec  (push_rec)
  );

  hcbd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .pop        (pop),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .full       (full)
  );

  hcbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop        (pop),
    .result     (result)
  );

endmodule

// ===== design/hcbd_front.sv =====
// Front part: accepts body bytes, runs the chunk framing parser, forms result records.
`include "http_chunked_body_decoder_unit_assert.svh"
module hcbd_front #(
  parameter int CHUNK_SIZE_BITS = 32,
  parameter int COUNT_BITS      = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                emit_data,
  hcbd_in_if.sink             body,
  input  logic                q_full,
  output logic                push,
  output hcbd_pkg::rec_t      push_rec
);

  localparam logic [2:0] PH_SIZE  = 3'd0;
  localparam logic [2:0] PH_EXT   = 3'd1;
  localparam logic [2:0] PH_DATA  = 3'd2;
  localparam logic [2:0] PH_DCR   = 3'd3;
  localparam logic [2:0] PH_DLF   = 3'd4;
  localparam logic [2:0] PH_TRAIL = 3'd5;
  localparam logic [2:0] PH_DONE  = 3'd6;
  localparam logic [2:0] PH_FAIL  = 3'd7;

  logic [2:0]                 phase, phase_next;
  logic                       cr_pending, cr_pending_next;
  logic                       line_nonempty, line_nonempty_next;
  logic [CHUNK_SIZE_BITS-1:0] chunk_count, chunk_count_next;
  logic [COUNT_BITS-1:0]      consumed_count, consumed_inc;
  logic [COUNT_BITS+31:0]     consumed_ext;
  logic [31:0]                consumed_sat;

  logic       accept, active, emit, oc_valid, incomplete;
  logic [2:0] oc_kind;
  logic [7:0] b;
  logic       is_hex;
  logic [3:0] hex_val;

  assign body.ready = !q_full;
  assign accept     = body.valid && body.ready;
  assign b          = body.data_byte;
  assign active     = (phase != PH_DONE) && (phase != PH_FAIL);

  // Decode a hex digit
  always_comb begin
    is_hex  = 1'b1;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      hex_val = 4'(b - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  // Saturating byte count, clipped to 32 bits for the report
  assign consumed_inc = (consumed_count == {COUNT_BITS{1'b1}}) ? consumed_count
                                                               : consumed_count + 1'b1;
  assign consumed_ext = (COUNT_BITS + 32)'(consumed_inc);
  assign consumed_sat = (consumed_ext > (COUNT_BITS + 32)'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                           : consumed_ext[31:0];

  // Framing parser: one byte per step
  always_comb begin
    phase_next         = phase;
    cr_pending_next    = cr_pending;
    line_nonempty_next = line_nonempty;
    chunk_count_next   = chunk_count;
    emit               = 1'b0;
    oc_valid           = 1'b0;
    oc_kind            = hcbd_pkg::KIND_BADSIZE;
    case (phase)
      PH_SIZE: begin
        if (cr_pending) begin
          cr_pending_next = 1'b0;
          if (b == hcbd_pkg::CH_LF && line_nonempty) begin
            line_nonempty_next = 1'b0;
            phase_next = (chunk_count == '0) ? PH_TRAIL : PH_DATA;
          end else begin
            oc_valid = 1'b1;
          end
        end else if (is_hex) begin
          if (chunk_count[CHUNK_SIZE_BITS-1 -: 4] != 4'd0) begin
            oc_valid = 1'b1;
            oc_kind  = hcbd_pkg::KIND_OVERFLOW;
          end else begin
            chunk_count_next   = {chunk_count[CHUNK_SIZE_BITS-5:0], hex_val};
            line_nonempty_next = 1'b1;
          end
        end else if (b == hcbd_pkg::CH_SEMI) begin
          if (line_nonempty) begin
            phase_next = PH_EXT;
          end else begin
            oc_valid = 1'b1;
          end
        end else if (b == hcbd_pkg::CH_CR) begin
          cr_pending_next = 1'b1;
        end else begin
          oc_valid = 1'b1;
        end
      end
      PH_EXT: begin
        if (b == hcbd_pkg::CH_LF && cr_pending) begin
          cr_pending_next    = 1'b0;
          line_nonempty_next = 1'b0;
          phase_next = (chunk_count == '0) ? PH_TRAIL : PH_DATA;
        end else begin
          cr_pending_next = (b == hcbd_pkg::CH_CR);
        end
      end
      PH_DATA: begin
        emit             = 1'b1;
        chunk_count_next = chunk_count - CHUNK_SIZE_BITS'(1);
        if (chunk_count == CHUNK_SIZE_BITS'(1)) begin
          phase_next = PH_DCR;
        end
      end
      PH_DCR: begin
        if (b != hcbd_pkg::CH_CR) begin
          oc_valid = 1'b1;
          oc_kind  = hcbd_pkg::KIND_NOCRLF;
        end else begin
          phase_next = PH_DLF;
        end
      end
      PH_DLF: begin
        if (b != hcbd_pkg::CH_LF) begin
          oc_valid = 1'b1;
          oc_kind  = hcbd_pkg::KIND_NOCRLF;
        end else begin
          phase_next         = PH_SIZE;
          chunk_count_next   = '0;
          line_nonempty_next = 1'b0;
          cr_pending_next    = 1'b0;
        end
      end
      PH_TRAIL: begin
        if (b == hcbd_pkg::CH_LF) begin
          if (cr_pending) begin
            if (!line_nonempty) begin
              oc_valid = 1'b1;
              oc_kind  = hcbd_pkg::KIND_COMPLETE;
            end else begin
              line_nonempty_next = 1'b0;
              cr_pending_next    = 1'b0;
            end
          end else begin
            line_nonempty_next = 1'b1;
          end
        end else if (b == hcbd_pkg::CH_CR) begin
          if (cr_pending) begin
            line_nonempty_next = 1'b1;
          end
          cr_pending_next = 1'b1;
        end else begin
          line_nonempty_next = 1'b1;
          cr_pending_next    = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign incomplete = body.end_of_buffer && active && !oc_valid;

  // Form the record for this beat
  always_comb begin
    push_rec.has_data    = active && emit && emit_data;
    push_rec.data        = b;
    push_rec.has_status  = active && (oc_valid || body.end_of_buffer);
    push_rec.status_kind = oc_valid ? oc_kind : hcbd_pkg::KIND_INCOMPLETE;
    push_rec.consumed    = (oc_valid && oc_kind == hcbd_pkg::KIND_COMPLETE) ? consumed_sat
                                                                            : 32'd0;
    push = accept && (push_rec.has_data || push_rec.has_status);
  end

  // Advance the parser state; re-arm at the end of a buffer
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_SIZE;
      cr_pending     <= 1'b0;
      line_nonempty  <= 1'b0;
      chunk_count    <= '0;
      consumed_count <= '0;
    end else if (accept) begin
      if (body.end_of_buffer) begin
        phase          <= PH_SIZE;
        cr_pending     <= 1'b0;
        line_nonempty  <= 1'b0;
        chunk_count    <= '0;
        consumed_count <= '0;
      end else if (active) begin
        cr_pending     <= cr_pending_next;
        line_nonempty  <= line_nonempty_next;
        chunk_count    <= chunk_count_next;
        consumed_count <= consumed_inc;
        if (oc_valid) begin
          phase <= (oc_kind == hcbd_pkg::KIND_COMPLETE) ? PH_DONE : PH_FAIL;
        end else begin
          phase <= phase_next;
        end
      end
    end
  end

  // A decided buffer yields nothing more
  `HCBD_ASSERT_NOW(a_quiet_after_outcome, !active, !push)
  // An undecided buffer end always reports
  `HCBD_ASSERT_NOW(a_incomplete_pushed, accept && incomplete, push && push_rec.has_status)

endmodule

// ===== design/hcbd_queue.sv =====
// Short record queue that decouples the parser from the output stage.
`include "http_chunked_body_decoder_unit_assert.svh"
module hcbd_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  hcbd_pkg::rec_t push_rec,
  input  logic           pop,
  output logic           head_valid,
  output hcbd_pkg::rec_t head_rec,
  output logic           full
);

  hcbd_pkg::rec_t                 entries [hcbd_pkg::QUEUE_DEPTH];
  logic [hcbd_pkg::QPTR_W-1:0]    wr_ptr, rd_ptr;
  logic [hcbd_pkg::QPTR_W:0]      count;

  assign full       = (count == (hcbd_pkg::QPTR_W + 1)'(hcbd_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = entries[rd_ptr];

  // Store records
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  `HCBD_ASSERT_NOW(a_no_overrun, full, !push)
  `HCBD_ASSERT_NOW(a_no_underrun, !head_valid, !pop)

endmodule

// ===== design/hcbd_back.sv =====
// Back part: unpacks queued records into single result beats on the output channel.
`include "http_chunked_body_decoder_unit_assert.svh"
module hcbd_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           head_valid,
  input  hcbd_pkg::rec_t head_rec,
  output logic           pop,
  hcbd_out_if.source     result
);

  logic        out_valid;
  logic [2:0]  out_kind;
  logic [7:0]  out_data;
  logic [31:0] out_consumed;
  logic        out_last;
  logic        pending;
  logic [2:0]  pend_kind;
  logic [31:0] pend_consumed;
  logic        load;

  assign load = !out_valid || result.ready;
  assign pop  = load && !pending && head_valid;

  assign result.valid    = out_valid;
  assign result.kind     = out_kind;
  assign result.data_out = out_data;
  assign result.consumed = out_consumed;
  assign result.last     = out_last;

  // Hold status behind its data beat
  always_ff @(posedge clk) begin
    if (pop) begin
      pend_kind     <= head_rec.status_kind;
      pend_consumed <= head_rec.consumed;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      pending   <= 1'b0;
    end else if (load) begin
      if (pending) begin
        out_valid <= 1'b1;
        pending   <= 1'b0;
      end else begin
        out_valid <= head_valid;
        pending   <= head_valid && head_rec.has_data && head_rec.has_status;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (pending) begin
        out_kind     <= pend_kind;
        out_data     <= 8'd0;
        out_consumed <= pend_consumed;
        out_last     <= 1'b1;
      end else if (head_rec.has_data) begin
        out_kind     <= hcbd_pkg::KIND_DATA;
        out_data     <= head_rec.data;
        out_consumed <= 32'd0;
        out_last     <= !head_rec.has_status;
      end else begin
        out_kind     <= head_rec.status_kind;
        out_data     <= 8'd0;
        out_consumed <= head_rec.consumed;
        out_last     <= 1'b1;
      end
    end
  end

  `HCBD_ASSERT_NOW(a_split_has_status, out_valid && !out_last, pending)
  `HCBD_ASSERT_NOW(a_status_is_last, out_valid && out_kind != hcbd_pkg::KIND_DATA, out_last)
  `HCBD_ASSERT_NEXT(a_status_follows, pending && result.ready, out_valid && out_last)

endmodule
